### rtl/flux_stream_decoder_top_assert.svh
// Assertion macros shared by the flux stream decoder RTL.
// FSD_ASSERT checks a property with reset disabling it.
// FSD_ASSERT_ALWAYS checks a property at every edge, reset included.
`ifndef FLUX_STREAM_DECODER_TOP_ASSERT_SVH
`define FLUX_STREAM_DECODER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define FSD_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define FSD_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FSD_ASSERT(label, clk, rst_n, prop, msg)
`define FSD_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

### rtl/fsd_pkg.sv
package fsd_pkg;

    localparam int BYTE_W     = 8;
    localparam int TICKS_W    = 32;
    localparam int KIND_W     = 2;
    localparam int ERR_W      = 2;
    localparam int ARG_W      = 28;
    localparam int ARG_DIGIT_W = 7;
    localparam int INTERVAL_W = 11;
    localparam int SINCE_W    = 34;

    localparam logic [BYTE_W-1:0] BYTE_ESCAPE    = 8'd255;
    localparam logic [BYTE_W-1:0] BYTE_LONG_BASE = 8'd250;
    localparam logic [BYTE_W-1:0] OPC_INDEX      = 8'd1;
    localparam logic [BYTE_W-1:0] OPC_SPACE      = 8'd2;

    // Long interval = 250 + prefix * 255 + next - 1
    localparam logic [INTERVAL_W-1:0] LONG_OFFSET = 11'd249;
    localparam logic [INTERVAL_W-1:0] LONG_STEP   = 11'd255;

    typedef enum logic [KIND_W-1:0] {
        KIND_FLUX  = 2'd0,
        KIND_INDEX = 2'd1,
        KIND_END   = 2'd2,
        KIND_ERROR = 2'd3
    } fsd_kind_t;

    typedef enum logic [ERR_W-1:0] {
        ERR_BAD_OPCODE = 2'd0,
        ERR_TRUNCATED  = 2'd1,
        ERR_NOT_ZERO   = 2'd2
    } fsd_err_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              last_byte;
    } fsd_item_t;

    typedef struct packed {
        fsd_kind_t          kind;
        logic [TICKS_W-1:0] ticks;
        fsd_err_t           error_code;
    } fsd_result_t;

endpackage

### rtl/fsd_byte_if.sv
interface fsd_byte_if;
    import fsd_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

### rtl/fsd_result_if.sv
interface fsd_result_if;
    import fsd_pkg::*;

    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  kind;
    logic [TICKS_W-1:0] ticks;
    logic [ERR_W-1:0]   error_code;

    modport source (output valid, output kind, output ticks, output error_code, input ready);
    modport sink   (input valid, input kind, input ticks, input error_code, output ready);
endinterface

### rtl/flux_stream_decoder_top.sv
// Channel   Direction  Transaction
// stream    sink       one raw flux byte (data_byte) with its last_byte flag
// events    source     one result: kind, ticks, error_code
//
// One byte per cycle sustained unless events stalls; a byte that yields a
// result passes the input register, then the parse and result register.
// rst_n clears the parser to idle with zero pending and index counts at once.
// Stalls on events hold the result register and back up into the input
// register; stream.ready drops only when both are full and events is stalled.
module flux_stream_decoder_top #(
    parameter int TICK_WIDTH = 32
) (
    input logic          clk,
    input logic          rst_n,
    fsd_byte_if.sink     stream,
    fsd_result_if.source events
);
    import fsd_pkg::*;

    fsd_item_t   byte_item;
    fsd_item_t   item;
    logic        item_valid;
    logic        item_take;
    fsd_result_t res;
    logic        res_valid;

    // Gather the byte channel into one item for the input register
    assign byte_item.data_byte = stream.data_byte;
    assign byte_item.last_byte = stream.last_byte;

    // Input register: decouples the byte source from the result stall path
    fsd_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (stream.valid),
        .byte_item  (byte_item),
        .byte_ready (stream.ready),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take)
    );

    // Parser state, saturating tick math and the result register
    fsd_core #(
        .TICK_WIDTH (TICK_WIDTH)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take),
        .res_valid  (res_valid),
        .res        (res),
        .res_ready  (events.ready)
    );

    // Drive the result channel straight from the result register
    assign events.valid      = res_valid;
    assign events.kind       = res.kind;
    assign events.ticks      = res.ticks;
    assign events.error_code = res.error_code;
endmodule

### rtl/fsd_in_stage.sv
module fsd_in_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              byte_valid,
    input  fsd_pkg::fsd_item_t byte_item,
    output logic              byte_ready,
    output logic              item_valid,
    output fsd_pkg::fsd_item_t item,
    input  logic              item_take
);
    import fsd_pkg::*;

    logic      item_valid_reg;
    logic      item_valid_next;
    fsd_item_t item_reg;

    // Refill whenever the held byte leaves or the stage is empty
    assign byte_ready = !item_valid_reg || item_take;

    always_comb
    begin
        item_valid_next = item_valid_reg;
        if (byte_ready)
        begin
            item_valid_next = byte_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_ready && byte_valid)
        begin
            item_reg <= byte_item;
        end
    end

    assign item_valid = item_valid_reg;
    assign item       = item_reg;
endmodule

### rtl/fsd_core.sv
`include "flux_stream_decoder_top_assert.svh"

module fsd_core #(
    parameter int TICK_WIDTH = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    input  fsd_pkg::fsd_item_t   item,
    output logic                 item_take,
    output logic                 res_valid,
    output fsd_pkg::fsd_result_t res,
    input  logic                 res_ready
);
    import fsd_pkg::*;

    localparam int CAP_W = (TICK_WIDTH < TICKS_W) ? TICK_WIDTH : TICKS_W;
    localparam int SUM_W = CAP_W + 1;
    localparam int WIDE_W = SINCE_W + 1;
    localparam logic [CAP_W-1:0]   CAP     = {CAP_W{1'b1}};
    localparam logic [SINCE_W-1:0] SI_MAX  = {1'b0, {(SINCE_W-1){1'b1}}};

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_LONG,
        PH_OPCODE,
        PH_ARGS,
        PH_ERROR
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic [2:0]         long_prefix_reg, long_prefix_next;
    logic               op_is_index_reg, op_is_index_next;
    logic [1:0]         arg_seen_reg, arg_seen_next;
    logic [ARG_W-1:0]   arg_accum_reg, arg_accum_next;
    logic [CAP_W-1:0]   pending_reg, pending_next;
    logic [SINCE_W-1:0] since_reg, since_next;
    logic               res_valid_reg, res_valid_next;
    fsd_result_t        res_reg, res_next;
    logic               res_load;

    logic [BYTE_W-1:0]     b;
    logic [INTERVAL_W-1:0] interval;
    logic [SUM_W-1:0]      flux_sum;
    logic [CAP_W-1:0]      flux_t;
    logic [WIDE_W-1:0]     si_flux;
    logic [SINCE_W-1:0]    since_after_flux;
    logic [ARG_W-1:0]      arg_digit;
    logic [ARG_W-1:0]      arg_full;
    logic [SUM_W-1:0]      arg_sum;
    logic [CAP_W-1:0]      space_t;
    logic [WIDE_W-1:0]     idx_v;
    logic [CAP_W-1:0]      idx_t;

    assign b = item.data_byte;

    // Hold the byte while a finished result is still waiting
    assign item_take = item_valid && (!res_valid_reg || res_ready);

    // Flux path: pending plus interval, then fold into the index counter
    always_comb
    begin
        if (phase_reg == PH_LONG)
        begin
            interval = LONG_OFFSET + INTERVAL_W'(long_prefix_reg) * LONG_STEP
                       + INTERVAL_W'(b);
        end
        else
        begin
            interval = INTERVAL_W'(b);
        end
        flux_sum = SUM_W'(pending_reg) + SUM_W'(interval);
        flux_t   = flux_sum[CAP_W] ? CAP : flux_sum[CAP_W-1:0];
        si_flux  = {since_reg[SINCE_W-1], since_reg} + WIDE_W'(flux_t);
        since_after_flux = (si_flux[WIDE_W-1] != si_flux[WIDE_W-2]) ?
                           SI_MAX : si_flux[SINCE_W-1:0];
    end

    // Argument path: the last byte supplies the top seven bits
    always_comb
    begin
        unique case (arg_seen_reg)
            2'd0:    arg_digit = ARG_W'(b[BYTE_W-1:1]);
            2'd1:    arg_digit = ARG_W'(b[BYTE_W-1:1]) << ARG_DIGIT_W;
            2'd2:    arg_digit = ARG_W'(b[BYTE_W-1:1]) << (2 * ARG_DIGIT_W);
            default: arg_digit = ARG_W'(b[BYTE_W-1:1]) << (3 * ARG_DIGIT_W);
        endcase
        arg_full = arg_accum_reg | arg_digit;
        arg_sum  = SUM_W'(pending_reg) + SUM_W'(arg_full);
        space_t  = arg_sum[CAP_W] ? CAP : arg_sum[CAP_W-1:0];
        idx_v    = {since_reg[SINCE_W-1], since_reg} + WIDE_W'(arg_sum);
        if (idx_v[WIDE_W-1])
        begin
            idx_t = '0;
        end
        else if (idx_v > WIDE_W'(CAP))
        begin
            idx_t = CAP;
        end
        else
        begin
            idx_t = idx_v[CAP_W-1:0];
        end
    end

    always_comb
    begin
        phase_next       = phase_reg;
        long_prefix_next = long_prefix_reg;
        op_is_index_next = op_is_index_reg;
        arg_seen_next    = arg_seen_reg;
        arg_accum_next   = arg_accum_reg;
        pending_next     = pending_reg;
        since_next       = since_reg;
        res_next         = res_reg;
        res_load         = 1'b0;

        if (item_take)
        begin
            if (item.last_byte)
            begin
                if (phase_reg != PH_ERROR)
                begin
                    res_load            = 1'b1;
                    res_next.ticks      = '0;
                    res_next.error_code = ERR_BAD_OPCODE;
                    if (b != '0)
                    begin
                        res_next.kind       = KIND_ERROR;
                        res_next.error_code = ERR_NOT_ZERO;
                    end
                    else if (phase_reg != PH_IDLE)
                    begin
                        res_next.kind       = KIND_ERROR;
                        res_next.error_code = ERR_TRUNCATED;
                    end
                    else
                    begin
                        res_next.kind = KIND_END;
                    end
                end
                phase_next       = PH_IDLE;
                long_prefix_next = '0;
                op_is_index_next = 1'b0;
                arg_seen_next    = '0;
                arg_accum_next   = '0;
                pending_next     = '0;
                since_next       = '0;
            end
            else
            begin
                unique case (phase_reg)
                    PH_IDLE, PH_LONG:
                    begin
                        if (phase_reg == PH_IDLE && b == BYTE_ESCAPE)
                        begin
                            phase_next = PH_OPCODE;
                        end
                        else if (phase_reg == PH_IDLE && b >= BYTE_LONG_BASE)
                        begin
                            long_prefix_next = 3'(b - BYTE_LONG_BASE);
                            phase_next       = PH_LONG;
                        end
                        else
                        begin
                            res_load            = 1'b1;
                            res_next.kind       = KIND_FLUX;
                            res_next.ticks      = TICKS_W'(flux_t);
                            res_next.error_code = ERR_BAD_OPCODE;
                            since_next          = since_after_flux;
                            pending_next        = '0;
                            long_prefix_next    = '0;
                            phase_next          = PH_IDLE;
                        end
                    end
                    PH_OPCODE:
                    begin
                        if (b == OPC_INDEX || b == OPC_SPACE)
                        begin
                            op_is_index_next = (b == OPC_INDEX);
                            arg_seen_next    = '0;
                            arg_accum_next   = '0;
                            phase_next       = PH_ARGS;
                        end
                        else
                        begin
                            res_load            = 1'b1;
                            res_next.kind       = KIND_ERROR;
                            res_next.ticks      = '0;
                            res_next.error_code = ERR_BAD_OPCODE;
                            phase_next          = PH_ERROR;
                        end
                    end
                    PH_ARGS:
                    begin
                        if (arg_seen_reg != 2'd3)
                        begin
                            arg_accum_next = arg_full;
                            arg_seen_next  = arg_seen_reg + 2'd1;
                        end
                        else
                        begin
                            if (op_is_index_reg)
                            begin
                                res_load            = 1'b1;
                                res_next.kind       = KIND_INDEX;
                                res_next.ticks      = TICKS_W'(idx_t);
                                res_next.error_code = ERR_BAD_OPCODE;
                                since_next          = SINCE_W'(0) - SINCE_W'(arg_sum);
                            end
                            else
                            begin
                                pending_next = space_t;
                            end
                            arg_seen_next    = '0;
                            arg_accum_next   = '0;
                            op_is_index_next = 1'b0;
                            phase_next       = PH_IDLE;
                        end
                    end
                    default:
                    begin
                        // Drop bytes until the closing byte
                        phase_next = PH_ERROR;
                    end
                endcase
            end
        end

        if (res_load)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            long_prefix_reg <= '0;
            op_is_index_reg <= 1'b0;
            arg_seen_reg    <= '0;
            arg_accum_reg   <= '0;
            pending_reg     <= '0;
            since_reg       <= '0;
            res_valid_reg   <= 1'b0;
            res_reg         <= '0;
        end
        else
        begin
            phase_reg       <= phase_next;
            long_prefix_reg <= long_prefix_next;
            op_is_index_reg <= op_is_index_next;
            arg_seen_reg    <= arg_seen_next;
            arg_accum_reg   <= arg_accum_next;
            pending_reg     <= pending_next;
            since_reg       <= since_next;
            res_valid_reg   <= res_valid_next;
            res_reg         <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    `FSD_ASSERT_ALWAYS(a_code_only_on_error, clk, res_valid_reg && res_reg.kind != KIND_ERROR |-> res_reg.error_code == ERR_BAD_OPCODE, "error code set on a non-error result")
    `FSD_ASSERT(a_last_clears_state, clk, rst_n, item_take && item.last_byte |=> phase_reg == PH_IDLE && pending_reg == '0 && since_reg == '0, "state not cleared after closing byte")
    `FSD_ASSERT(a_error_is_silent, clk, rst_n, item_take && !item.last_byte && phase_reg == PH_ERROR |-> !res_load, "result produced while discarding")
    `FSD_ASSERT(a_flux_drains_pending, clk, rst_n, res_load && res_next.kind == KIND_FLUX |=> pending_reg == '0, "pending ticks kept after flux")
    `FSD_ASSERT(a_stall_blocks_take, clk, rst_n, res_valid_reg && !res_ready |-> !item_take, "byte taken over a waiting result")
endmodule

### test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import fsd_pkg::*;

    // Tick width the decoder is built with; results saturate at 2^min(W,32) - 1.
    localparam int DUT_TICK_WIDTH = 32;
    localparam longint unsigned TICK_CAP = (DUT_TICK_WIDTH >= 32) ?
        64'hFFFF_FFFF : ((64'd1 << DUT_TICK_WIDTH) - 64'd1);

    // Index distance is a 34-bit signed count.
    localparam longint SINCE_HI = 64'sd8589934591;
    localparam longint SINCE_LO = -64'sd8589934592;

    localparam logic [ARG_W-1:0] ARG_FULL = {ARG_W{1'b1}};

    localparam int RANDOM_ITEMS   = 1150;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 10;

    // error_code reads zero on every result that is not an error.
    localparam fsd_err_t ERR_NONE = ERR_BAD_OPCODE;

    typedef enum logic [2:0] {
        P_IDLE,
        P_LONG,
        P_OPCODE,
        P_ARGS,
        P_ERROR
    } parse_phase_t;

    typedef enum logic [1:0] {
        RDY_ALWAYS,
        RDY_RANDOM,
        RDY_PULSED,
        RDY_LONG_STALL
    } ready_mode_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b1;

    fsd_byte_if   stream_if ();
    fsd_result_if events_if ();

    flux_stream_decoder_top #(
        .TICK_WIDTH(DUT_TICK_WIDTH)
    ) u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .stream (stream_if),
        .events (events_if)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Parser mirror: tracks the decoder's state one accepted byte at a time
    // and queues the event each byte should produce.
    // ------------------------------------------------------------------
    parse_phase_t     parse_phase;
    logic [2:0]       long_prefix;
    logic             arg_for_index;
    logic [1:0]       arg_count;
    logic [ARG_W-1:0] arg_value;
    longint unsigned  pending_space;
    longint           since_mark;

    fsd_result_t expected_events[$];

    int unsigned fail_count = 0;

    function automatic longint unsigned cap_ticks(input longint unsigned v);
        return (v > TICK_CAP) ? TICK_CAP : v;
    endfunction

    function automatic longint clamp_since(input longint v);
        if (v > SINCE_HI)
            return SINCE_HI;
        if (v < SINCE_LO)
            return SINCE_LO;
        return v;
    endfunction

    task automatic clear_parser();
        parse_phase   = P_IDLE;
        long_prefix   = '0;
        arg_for_index = 1'b0;
        arg_count     = '0;
        arg_value     = '0;
        pending_space = 0;
        since_mark    = 0;
    endtask

    task automatic expect_event(input fsd_kind_t kind, input longint unsigned ticks,
                                input fsd_err_t code);
        fsd_result_t ev;
        ev.kind       = kind;
        ev.ticks      = ticks[TICKS_W-1:0];
        ev.error_code = code;
        expected_events.push_back(ev);
    endtask

    // Flux result: pending space plus the interval, then clear the pending space.
    task automatic flux_event(input longint unsigned interval);
        longint unsigned t;
        t = cap_ticks(pending_space + interval);
        since_mark = clamp_since(since_mark + longint'(t));
        pending_space = 0;
        expect_event(KIND_FLUX, t, ERR_NONE);
    endtask

    task automatic decode_byte(input logic [BYTE_W-1:0] b, input logic last);
        longint sum;
        longint idx_span;
        longint unsigned t;
        if (last)
        begin
            // Bytes after an error are swallowed, terminator included.
            if (parse_phase != P_ERROR)
            begin
                if (b != '0)
                    expect_event(KIND_ERROR, 0, ERR_NOT_ZERO);
                else if (parse_phase != P_IDLE)
                    expect_event(KIND_ERROR, 0, ERR_TRUNCATED);
                else
                    expect_event(KIND_END, 0, ERR_NONE);
            end
            clear_parser();
            return;
        end
        case (parse_phase)
            P_IDLE:
            begin
                if (b == BYTE_ESCAPE)
                    parse_phase = P_OPCODE;
                else if (b >= BYTE_LONG_BASE)
                begin
                    long_prefix = 3'(b - BYTE_LONG_BASE);
                    parse_phase = P_LONG;
                end
                else
                    flux_event(longint'(b));
            end
            P_LONG:
            begin
                flux_event(longint'(BYTE_LONG_BASE) + longint'(long_prefix) * 255
                           + longint'(b) - 1);
                long_prefix = '0;
                parse_phase = P_IDLE;
            end
            P_OPCODE:
            begin
                if (b == OPC_INDEX || b == OPC_SPACE)
                begin
                    arg_for_index = (b == OPC_INDEX);
                    arg_count     = '0;
                    arg_value     = '0;
                    parse_phase   = P_ARGS;
                end
                else
                begin
                    expect_event(KIND_ERROR, 0, ERR_BAD_OPCODE);
                    parse_phase = P_ERROR;
                end
            end
            P_ARGS:
            begin
                // Upper seven bits of each byte, least significant digit first.
                arg_value = arg_value | (ARG_W'(b[7:1]) << (ARG_DIGIT_W * arg_count));
                if (arg_count != 2'd3)
                    arg_count = arg_count + 2'd1;
                else
                begin
                    if (arg_for_index)
                    begin
                        sum      = longint'(pending_space) + longint'(arg_value);
                        idx_span = since_mark + sum;
                        if (idx_span < 0)
                            t = 0;
                        else
                            t = cap_ticks(longint'(idx_span));
                        expect_event(KIND_INDEX, t, ERR_NONE);
                        since_mark = clamp_since(-sum);
                    end
                    else
                        pending_space = cap_ticks(pending_space + longint'(arg_value));
                    arg_count     = '0;
                    arg_value     = '0;
                    arg_for_index = 1'b0;
                    parse_phase   = P_IDLE;
                end
            end
            default:
                ;
        endcase
    endtask

    // ------------------------------------------------------------------
    // Stimulus: byte stream built up front, drained by the driver.
    // ------------------------------------------------------------------
    fsd_item_t   byte_queue[$];
    int unsigned random_count = 0;

    // Push one byte; bytes that the decoder merely drops do not count.
    task automatic put_byte(input logic [BYTE_W-1:0] b, input logic last,
                            input bit counted);
        fsd_item_t it;
        it.data_byte = b;
        it.last_byte = last;
        byte_queue.push_back(it);
        if (counted)
            random_count++;
    endtask

    task automatic put_long(input int unsigned prefix, input int unsigned next_byte);
        put_byte(BYTE_LONG_BASE + BYTE_W'(prefix), 1'b0, 1'b1);
        put_byte(BYTE_W'(next_byte), 1'b0, 1'b1);
    endtask

    // Escape, opcode, then the requested argument digits with a random don't-care bit.
    task automatic put_command(input logic [BYTE_W-1:0] opc, input logic [ARG_W-1:0] arg,
                               input int unsigned digits);
        put_byte(BYTE_ESCAPE, 1'b0, 1'b1);
        put_byte(opc, 1'b0, 1'b1);
        for (int k = 0; k < digits; k++)
            put_byte({arg[ARG_DIGIT_W*k +: ARG_DIGIT_W], 1'($urandom_range(0, 1))},
                     1'b0, 1'b1);
    endtask

    function automatic logic [BYTE_W-1:0] bad_opcode();
        logic [BYTE_W-1:0] op;
        do
            op = BYTE_W'($urandom_range(0, 255));
        while (op == OPC_INDEX || op == OPC_SPACE);
        return op;
    endfunction

    function automatic logic [ARG_W-1:0] random_arg();
        case ($urandom_range(0, 3))
            0:       return ARG_FULL;
            1:       return ARG_W'($urandom_range(0, 300));
            default: return ARG_W'($urandom);
        endcase
    endfunction

    task automatic directed_stimulus();
        // Shortest and longest short intervals, then both ends of the long form.
        put_byte(8'd0, 1'b0, 1'b0);
        put_byte(8'd249, 1'b0, 1'b0);
        put_long(0, 0);
        put_long(4, 255);
        // Large index argument drives the index distance negative, a flux
        // brings it back only partly, so the next index clips at zero.
        put_command(OPC_INDEX, ARG_FULL, 4);
        put_byte(8'd3, 1'b0, 1'b0);
        put_command(OPC_INDEX, '0, 4);
        put_byte(8'd0, 1'b1, 1'b0);
        // Bad opcode, a dropped byte, then a terminator that is also dropped.
        put_byte(BYTE_ESCAPE, 1'b0, 1'b0);
        put_byte(8'd0, 1'b0, 1'b0);
        put_byte(8'h55, 1'b0, 1'b0);
        put_byte(8'hFF, 1'b1, 1'b0);
        // Terminator that is not zero.
        put_byte(8'h80, 1'b1, 1'b0);
        // Zero terminator in the middle of a command.
        put_byte(BYTE_ESCAPE, 1'b0, 1'b0);
        put_byte(8'd0, 1'b1, 1'b0);
    endtask

    // One stream of tokens closed by a terminator. Heavy streams pile up
    // space so that pending, flux, index distance and index results saturate.
    task automatic random_stream(input bit heavy);
        int unsigned tokens;
        int unsigned pick;
        int unsigned noise;
        tokens = heavy ? $urandom_range(40, 70) : $urandom_range(1, 40);
        for (int i = 0; i < tokens; i++)
        begin
            pick = $urandom_range(0, 99);
            if (heavy)
            begin
                if (pick < 65)
                    put_command(OPC_SPACE, ARG_FULL, 4);
                else if (pick < 95)
                    put_byte(BYTE_W'($urandom_range(0, 249)), 1'b0, 1'b1);
                else
                    put_command(OPC_INDEX, random_arg(), 4);
            end
            else if (pick < 35)
                put_byte(BYTE_W'($urandom_range(0, 249)), 1'b0, 1'b1);
            else if (pick < 55)
                put_long($urandom_range(0, 4), $urandom_range(0, 255));
            else if (pick < 70)
                put_command(OPC_SPACE, random_arg(), 4);
            else if (pick < 85)
                put_command(OPC_INDEX, random_arg(), 4);
            else if (pick < 90)
            begin
                // Bad opcode: everything up to and including the terminator is dropped.
                put_byte(BYTE_ESCAPE, 1'b0, 1'b1);
                put_byte(bad_opcode(), 1'b0, 1'b1);
                noise = $urandom_range(0, 5);
                for (int n = 0; n < noise; n++)
                    put_byte(BYTE_W'($urandom_range(0, 255)), 1'b0, 1'b0);
                put_byte(BYTE_W'($urandom_range(0, 255)), 1'b1, 1'b0);
                return;
            end
            else
                put_byte(BYTE_W'($urandom_range(0, 249)), 1'b0, 1'b1);
        end
        case ($urandom_range(0, 9))
            0:
                put_byte(BYTE_W'($urandom_range(1, 255)), 1'b1, 1'b1);
            1:
            begin
                // Cut a sequence short before the terminator.
                case ($urandom_range(0, 3))
                    0: put_byte(BYTE_W'($urandom_range(250, 254)), 1'b0, 1'b1);
                    1: put_byte(BYTE_ESCAPE, 1'b0, 1'b1);
                    2: put_command($urandom_range(0, 1) ? OPC_INDEX : OPC_SPACE, '0, 0);
                    default:
                        put_command($urandom_range(0, 1) ? OPC_INDEX : OPC_SPACE,
                                    random_arg(), $urandom_range(1, 3));
                endcase
                if ($urandom_range(0, 3) == 0)
                    put_byte(BYTE_W'($urandom_range(1, 255)), 1'b1, 1'b1);
                else
                    put_byte(8'd0, 1'b1, 1'b1);
            end
            default:
                put_byte(8'd0, 1'b1, 1'b1);
        endcase
    endtask

    // ------------------------------------------------------------------
    // Driver: send bytes in bursts with random gaps, hold each byte until
    // its transaction completes, and feed the mirror on every acceptance.
    // ------------------------------------------------------------------
    int unsigned burst_left;
    int unsigned gap_left;
    fsd_item_t   next_item;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stream_if.valid     <= 1'b0;
            stream_if.data_byte <= '0;
            stream_if.last_byte <= 1'b0;
            burst_left          <= 0;
            gap_left            <= 0;
            clear_parser();
        end
        else
        begin
            if (stream_if.valid && stream_if.ready)
                decode_byte(stream_if.data_byte, stream_if.last_byte);
            // Hold the current byte while the transaction is pending.
            if (!stream_if.valid || stream_if.ready)
            begin
                if (gap_left != 0 || byte_queue.size() == 0)
                begin
                    stream_if.valid <= 1'b0;
                    if (gap_left != 0)
                        gap_left <= gap_left - 1;
                end
                else
                begin
                    next_item = byte_queue.pop_front();
                    stream_if.valid     <= 1'b1;
                    stream_if.data_byte <= next_item.data_byte;
                    stream_if.last_byte <= next_item.last_byte;
                    // Close the burst and pick the next gap; zero gaps keep
                    // some stretches back to back.
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 40);
                        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: stall the event channel on a changing pattern and compare
    // each event transaction against the oldest expectation.
    // ------------------------------------------------------------------
    ready_mode_t ready_mode;
    int unsigned mode_left;
    logic [4:0]  stall_phase;

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("%s", msg);
    endtask

    task automatic check_event();
        fsd_result_t want;
        if (expected_events.size() == 0)
        begin
            note_failure($sformatf("unexpected event: kind %0d ticks %0d code %0d",
                                   events_if.kind, events_if.ticks, events_if.error_code));
            return;
        end
        want = expected_events.pop_front();
        if (events_if.kind !== want.kind || events_if.ticks !== want.ticks
            || events_if.error_code !== want.error_code)
            note_failure($sformatf(
                "event mismatch: expected kind %0d ticks %0d code %0d, got kind %0d ticks %0d code %0d",
                want.kind, want.ticks, want.error_code,
                events_if.kind, events_if.ticks, events_if.error_code));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            events_if.ready <= 1'b0;
            ready_mode      <= RDY_ALWAYS;
            mode_left       <= 0;
            stall_phase     <= '0;
        end
        else
        begin
            if (events_if.valid && events_if.ready)
                check_event();
            // Switch stall pattern when the mode countdown reaches zero.
            if (mode_left == 0)
            begin
                ready_mode <= ready_mode_t'($urandom_range(0, 3));
                mode_left  <= $urandom_range(40, 250);
            end
            else
                mode_left <= mode_left - 1;
            stall_phase <= stall_phase + 5'd1;
            case (ready_mode)
                RDY_ALWAYS:  events_if.ready <= 1'b1;
                RDY_RANDOM:  events_if.ready <= ($urandom_range(0, 2) != 0);
                RDY_PULSED:  events_if.ready <= (stall_phase[3:2] == 2'b00);
                default:     events_if.ready <= (stall_phase >= 5'd18);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: abort when no transaction completes on either side for too long.
    // ------------------------------------------------------------------
    int unsigned quiet_cycles = 0;

    always @(posedge clk)
    begin
        if (!rst_n || (stream_if.valid && stream_if.ready)
            || (events_if.valid && events_if.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ------------------------------------------------------------------
    // Sequence: build stimulus, release reset, drain, report.
    // ------------------------------------------------------------------
    initial
    begin
        rst_n <= 1'b0;
        directed_stimulus();
        random_stream(1'b1);
        while (random_count < RANDOM_ITEMS)
            random_stream($urandom_range(0, 9) == 0);
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        // Sample on the falling edge so driver and monitor updates have settled.
        while (byte_queue.size() != 0 || stream_if.valid || expected_events.size() != 0)
            @(negedge clk);
        // Give any stray extra event time to show up.
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
